// ===== rtl/qte_pkg.sv =====
// shared types, widths, latencies and the arctangent table
// for the quaternion to euler angle pipeline; no dependencies
package qte_pkg;

  localparam int CordicStages = 16;
  localparam int TabLen       = 24;
  localparam int NumStages    = (CordicStages < TabLen) ? CordicStages : TabLen;

  localparam int ArgW  = 34;
  localparam int CW    = 38;
  localparam int AccW  = 34;
  localparam int SW    = 32;
  localparam int SqrtW = 31;
  localparam int RemW  = 61;

  localparam int FrontLat  = 4;
  localparam int CordicLat = NumStages + 1;
  localparam int TotLat    = FrontLat + SqrtW + CordicLat;
  localparam int Latency   = TotLat + 1;

  localparam logic signed [ArgW-1:0] One30    = 34'sd1073741824;
  localparam logic signed [ArgW-1:0] MinusOne = -34'sd1073741824;
  localparam logic signed [AccW-1:0] HalfPi   = 34'sd1073741824;
  localparam logic signed [17:0]     PitchMax = 18'sd16384;
  localparam logic signed [17:0]     PitchMin = -18'sd16384;

  localparam logic signed [AccW-1:0] AtanTab [TabLen] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } euler_t;

  typedef struct packed {
    logic signed [ArgW-1:0] roll_y;
    logic signed [ArgW-1:0] roll_x;
    logic signed [ArgW-1:0] yaw_y;
    logic signed [ArgW-1:0] yaw_x;
    logic signed [SW-1:0]   pitch_s;
  } side_t;

endpackage

// ===== rtl/qte_front.sv =====
// front end: quaternion products, atan2 arguments, clamped sine term
// and the radicand 2^60 - s^2; uses qte_pkg
module qte_front (
  input  logic                        clk_i,
  input  qte_pkg::quat_t              quat_i,
  output qte_pkg::side_t              side_o,
  output logic [qte_pkg::RemW-1:0]    rad_o
);

  localparam int SW_TOP = qte_pkg::SW - 1;

  logic signed [31:0] wx_q, yz_q, wz_q, xy_q, wy_q, zx_q, xx_q, yy_q, zz_q;
  qte_pkg::side_t side2_d, side2_q, side3_q, side4_q;
  logic signed [qte_pkg::ArgW-1:0] s_raw;
  logic [30:0] s_mag;
  logic [29:0] aa_q;
  logic [30:0] ab_q;
  logic [31:0] bb_q;
  logic [61:0] sq;
  logic [qte_pkg::RemW-1:0] rad_q;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    wx_q <= quat_i.quat_w * quat_i.quat_x;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    wz_q <= quat_i.quat_w * quat_i.quat_z;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    wy_q <= quat_i.quat_w * quat_i.quat_y;
    zx_q <= quat_i.quat_z * quat_i.quat_x;
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
  end

  // stage 2: sums
  always_comb begin
    side2_d.roll_y = (34'(wx_q) + 34'(yz_q)) <<< 1;
    side2_d.roll_x = qte_pkg::One30 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    side2_d.yaw_y  = (34'(wz_q) + 34'(xy_q)) <<< 1;
    side2_d.yaw_x  = qte_pkg::One30 - ((34'(yy_q) + 34'(zz_q)) <<< 1);
    s_raw          = (34'(wy_q) - 34'(zx_q)) <<< 1;
    if (s_raw > qte_pkg::One30) begin
      side2_d.pitch_s = 32'(qte_pkg::One30);
    end else if (s_raw < qte_pkg::MinusOne) begin
      side2_d.pitch_s = 32'(qte_pkg::MinusOne);
    end else begin
      side2_d.pitch_s = 32'(s_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
  end

  // stage 3: s^2 as partial products
  always_comb begin
    s_mag = side2_q.pitch_s[SW_TOP] ? 31'(-side2_q.pitch_s) : side2_q.pitch_s[30:0];
  end

  always_ff @(posedge clk_i) begin
    aa_q    <= 30'(s_mag[30:16] * s_mag[30:16]);
    ab_q    <= 31'(s_mag[30:16] * s_mag[15:0]);
    bb_q    <= s_mag[15:0] * s_mag[15:0];
    side3_q <= side2_q;
  end

  // stage 4: radicand
  always_comb begin
    sq = 62'({aa_q, 32'b0}) + 62'({ab_q, 17'b0}) + 62'(bb_q);
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= 61'((62'(1) << 60) - sq);
    side4_q <= side3_q;
  end

  assign side_o = side4_q;
  assign rad_o  = rad_q;

endmodule

// ===== rtl/qte_isqrt.sv =====
// pipelined integer square root, one result bit per stage,
// with the atan2 arguments carried alongside; uses qte_pkg
module qte_isqrt (
  input  logic                        clk_i,
  input  logic [qte_pkg::RemW-1:0]    rad_i,
  input  qte_pkg::side_t              side_i,
  output logic [qte_pkg::SqrtW-1:0]   root_o,
  output qte_pkg::side_t              side_o
);

  localparam int N = qte_pkg::SqrtW;

  logic [qte_pkg::RemW-1:0]  rem_q  [N+1];
  logic [N-1:0]              root_q [N+1];
  qte_pkg::side_t            side_q [N+1];

  assign rem_q[0]  = rad_i;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic [62:0] trial;
    logic        take;

    assign trial = ({32'b0, root_q[j]} << (K + 1)) | (63'(1) << (2 * K));
    assign take  = {2'b0, rem_q[j]} >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= take ? rem_q[j] - trial[qte_pkg::RemW-1:0] : rem_q[j];
      root_q[j+1] <= take ? (root_q[j] | (N'(1) << K)) : root_q[j];
      side_q[j+1] <= side_q[j];
    end
  end

  assign root_o = root_q[N];
  assign side_o = side_q[N];

endmodule

// ===== rtl/qte_cordic.sv =====
// pipelined cordic vectoring atan2 with quadrant pre-rotation,
// one micro-rotation per stage; uses qte_pkg
module qte_cordic (
  input  logic                              clk_i,
  input  logic signed [qte_pkg::ArgW-1:0]   y_i,
  input  logic signed [qte_pkg::ArgW-1:0]   x_i,
  output logic signed [qte_pkg::AccW-1:0]   acc_o
);

  localparam int N  = qte_pkg::NumStages;
  localparam int CW = qte_pkg::CW;

  logic signed [CW-1:0]            x_q   [N+1];
  logic signed [CW-1:0]            y_q   [N+1];
  logic signed [qte_pkg::AccW-1:0] acc_q [N+1];
  logic                            z_q   [N+1];

  logic signed [CW-1:0]            xe, ye, x0_d, y0_d;
  logic signed [qte_pkg::AccW-1:0] acc0_d;

  // quadrant pre-rotation
  always_comb begin
    xe = {{(CW - qte_pkg::ArgW){x_i[qte_pkg::ArgW-1]}}, x_i};
    ye = {{(CW - qte_pkg::ArgW){y_i[qte_pkg::ArgW-1]}}, y_i};
    x0_d   = xe;
    y0_d   = ye;
    acc0_d = '0;
    if (xe[CW-1]) begin
      if (!ye[CW-1]) begin
        x0_d   = ye;
        y0_d   = -xe;
        acc0_d = qte_pkg::HalfPi;
      end else begin
        x0_d   = -ye;
        y0_d   = xe;
        acc0_d = -qte_pkg::HalfPi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= x0_d;
    y_q[0]   <= y0_d;
    acc_q[0] <= acc0_d;
    z_q[0]   <= (x_i == '0) && (y_i == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (!y_q[i][CW-1]) begin
        x_q[i+1]   <= x_q[i] + ys;
        y_q[i+1]   <= y_q[i] - xs;
        acc_q[i+1] <= acc_q[i] + qte_pkg::AtanTab[i];
      end else begin
        x_q[i+1]   <= x_q[i] - ys;
        y_q[i+1]   <= y_q[i] + xs;
        acc_q[i+1] <= acc_q[i] - qte_pkg::AtanTab[i];
      end
      z_q[i+1] <= z_q[i];
    end
  end

  assign acc_o = z_q[N] ? '0 : acc_q[N];

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// top level: quaternion in, roll/pitch/yaw binary angles out
// uses qte_pkg, qte_front, qte_isqrt, qte_cordic
//
//  channel | signals                 | beat taken when
//  --------+-------------------------+--------------------
//  in      | start, busy, quat_i     | start && !busy
//  out     | done_o, euler_o         | done_o (one cycle)
//
// one quaternion per cycle; busy stays low
// a quaternion passes the front stages, the square root stages (one per result
// bit), a cordic pre-rotation register, the cordic stages and one output register
// the square root pipeline sets most of the latency
// reset clears only the valid line; the receiver cannot stall
module quaternion_to_euler_angles (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  qte_pkg::quat_t  quat_i,
  output logic            done_o,
  output qte_pkg::euler_t euler_o
);

  localparam int L = qte_pkg::TotLat;

  qte_pkg::side_t                  front_side, sqrt_side;
  logic [qte_pkg::RemW-1:0]        rad;
  logic [qte_pkg::SqrtW-1:0]       root;
  logic signed [qte_pkg::AccW-1:0] roll_acc, pitch_acc, yaw_acc;
  logic signed [qte_pkg::AccW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [17:0]              pitch_w;
  logic [L-1:0]                    valid_d, valid_q;
  logic                            done_q;
  qte_pkg::euler_t                 euler_d, euler_q;

  assign busy = 1'b0;

  qte_front u_front (
    .clk_i  (clk_i),
    .quat_i (quat_i),
    .side_o (front_side),
    .rad_o  (rad)
  );

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad),
    .side_i (front_side),
    .root_o (root),
    .side_o (sqrt_side)
  );

  qte_cordic u_roll (
    .clk_i (clk_i),
    .y_i   (sqrt_side.roll_y),
    .x_i   (sqrt_side.roll_x),
    .acc_o (roll_acc)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .y_i   (qte_pkg::ArgW'(sqrt_side.pitch_s)),
    .x_i   ($signed({{(qte_pkg::ArgW - qte_pkg::SqrtW){1'b0}}, root})),
    .acc_o (pitch_acc)
  );

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .y_i   (sqrt_side.yaw_y),
    .x_i   (sqrt_side.yaw_x),
    .acc_o (yaw_acc)
  );

  // round to 16-bit binary angle; pitch clamped to a quarter turn either way
  always_comb begin
    roll_r  = (roll_acc + 34'sd32768) >>> 16;
    pitch_r = (pitch_acc + 34'sd32768) >>> 16;
    yaw_r   = (yaw_acc + 34'sd32768) >>> 16;
    pitch_w = pitch_r[17:0];
    if (pitch_w > qte_pkg::PitchMax) begin
      pitch_w = qte_pkg::PitchMax;
    end else if (pitch_w < qte_pkg::PitchMin) begin
      pitch_w = qte_pkg::PitchMin;
    end
    euler_d.roll_angle  = roll_r[15:0];
    euler_d.pitch_angle = pitch_w[15:0];
    euler_d.yaw_angle   = yaw_r[15:0];
  end

  assign valid_d = {valid_q[L-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= valid_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[L-1]) begin
      euler_q <= euler_d;
    end
  end

  assign done_o  = done_q;
  assign euler_o = euler_q;

endmodule

// ===== rtl/qte_checker.sv =====
// port-level checks for quaternion_to_euler_angles, bound to the top
// uses qte_pkg
module qte_props (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input qte_pkg::euler_t euler_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(qte_pkg::Latency) done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, qte_pkg::Latency))
    else $error("result without input beat");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(euler_o.pitch_angle) <= 16'sd16384 &&
                $signed(euler_o.pitch_angle) >= -16'sd16384))
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles qte_props u_qte_props (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .euler_o (euler_o)
);

// ===== test/qte_checker.sv =====
// euler angle checker: predicts roll, pitch and yaw for every accepted quaternion
// and compares each done beat in order; depends on qte_pkg
module qte_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  qte_pkg::quat_t  quat_i,
  input  logic            done_o,
  input  qte_pkg::euler_t euler_o,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  qte_pkg::euler_t angle_q[$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc, t, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 64'sd1 << 30;
      end else begin
        x = -y; y = t; acc = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < qte_pkg::NumStages; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; acc += longint'(qte_pkg::AtanTab[i]);
      end else begin
        x -= ys; y += xs; acc -= longint'(qte_pkg::AtanTab[i]);
      end
    end
    return fshr(acc + 32768, 16);
  endfunction

  function automatic qte_pkg::euler_t predict_angles(qte_pkg::quat_t q);
    longint x, y, z, w, s, p;
    longint unsigned c;
    longint one;
    qte_pkg::euler_t e;
    one = 64'sd1 << 30;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    e.roll_angle = 16'(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    e.yaw_angle  = 16'(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = isqrt((64'd1 << 60) - longint'(s * s));
    p = vector_angle(s, longint'(c));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.pitch_angle = 16'(p);
    return e;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk_i) begin
    qte_pkg::euler_t want;
    if (rst_ni) begin
      if (start && !busy) angle_q.push_back(predict_angles(quat_i));
      if (done_o) begin
        if (angle_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = angle_q.pop_front();
          if (euler_o.roll_angle !== want.roll_angle)
            report("roll", euler_o.roll_angle, want.roll_angle);
          if (euler_o.pitch_angle !== want.pitch_angle)
            report("pitch", euler_o.pitch_angle, want.pitch_angle);
          if (euler_o.yaw_angle !== want.yaw_angle)
            report("yaw", euler_o.yaw_angle, want.yaw_angle);
        end
      end
    end
    pending = angle_q.size();
  end
endmodule

// ===== test/tb_top.sv =====
// top of the quaternion to euler testbench: clock, reset, quaternion stimulus
// and verdict; depends on qte_pkg, qte_checker and the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Items = 1750;
  localparam int StallLimit = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  qte_pkg::quat_t  quat_i = '0;
  logic            done_o;
  qte_pkg::euler_t euler_o;
  int              fail_count, pending;
  int              idle_cycles = 0;
  bit              timed_out = 1'b0;
  qte_pkg::quat_t  quat_list[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quaternion_to_euler_angles dut (.*);
  qte_checker chk (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qte_pkg::quat_t unit_quat();
    real a, b, c, d, n;
    qte_pkg::quat_t q;
    a = real'(int'($urandom_range(0, 2000)) - 1000);
    b = real'(int'($urandom_range(0, 2000)) - 1000);
    c = real'(int'($urandom_range(0, 2000)) - 1000);
    d = real'(int'($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin a = 1.0; n = 1.0; end
    q.quat_x = 16'($rtoi(a / n * 32767.0));
    q.quat_y = 16'($rtoi(b / n * 32767.0));
    q.quat_z = 16'($rtoi(c / n * 32767.0));
    q.quat_w = 16'($rtoi(d / n * 32767.0));
    return q;
  endfunction

  initial begin
    qte_pkg::quat_t q;
    bit calm;
    // identity, zeros, extremes, gimbal lock, half turns
    quat_list.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff});
    quat_list.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    quat_list.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    quat_list.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    quat_list.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    quat_list.push_back('{16'sh0000, 16'sh5a82, 16'sh0000, 16'sh5a82});
    quat_list.push_back('{16'sh0000, 16'sha57e, 16'sh0000, 16'sh5a82});
    quat_list.push_back('{16'sh0000, 16'sh7fff, 16'sh0000, 16'sh7fff});
    quat_list.push_back('{16'sh0000, 16'sh8000, 16'sh0000, 16'sh7fff});
    quat_list.push_back('{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000});
    quat_list.push_back('{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000});
    quat_list.push_back('{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000});
    quat_list.push_back('{16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000});
    quat_list.push_back('{16'sh5a82, 16'sh0000, 16'sh0000, 16'sh5a82});
    quat_list.push_back('{16'sha57e, 16'sh0000, 16'sh0000, 16'sh5a82});
    quat_list.push_back('{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000});
    quat_list.push_back('{16'sh0000, 16'shffff, 16'sh0000, 16'sh0001});
    quat_list.push_back('{16'sh0000, 16'sh0000, 16'sh0001, 16'shffff});
    quat_list.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    for (int i = 0; i < Items; i++) begin
      if ($urandom_range(0, 99) < 70) q = unit_quat();
      else q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      quat_list.push_back(q);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < quat_list.size(); i++) begin
      calm = (i >= 600 && i < 900);
      while (!calm && $urandom_range(0, 99) < 22) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      start  <= 1'b1;
      quat_i <= quat_list[i];
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (qte_pkg::Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
